FILE: rtl/core/ffec_pkg.sv
// Package for the four-floor elevator controller: phase codes, trip table,
// register indexes and relay helpers. No dependencies.
`default_nettype none

package ffec_pkg;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_OPEN_SHUT = 3'd1,
    PH_OPEN_ONLY = 3'd2,
    PH_SHUT_WAIT = 3'd3,
    PH_RUN       = 3'd4,
    PH_SETTLE    = 3'd5,
    PH_ARRIVE    = 3'd6,
    PH_SPARE     = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    LIM_NONE  = 2'd0,
    LIM_LOWER = 2'd1,
    LIM_UPPER = 2'd2
  } lim_e;

  localparam logic [2:0] CFG_TIMEOUT    = 3'd0;
  localparam logic [2:0] CFG_SETTLE     = 3'd1;
  localparam logic [2:0] CFG_DOOR_SHORT = 3'd2;
  localparam logic [2:0] CFG_DOOR_LONG  = 3'd3;
  localparam logic [2:0] CFG_CLOSE_HOLD = 3'd4;

  localparam logic [7:0] CH_FLOOR0 = 8'h31;
  localparam logic [7:0] CH_FLOOR3 = 8'h34;
  localparam logic [7:0] CH_TICK   = 8'h74; // 't'
  localparam logic [7:0] CH_UPPER  = 8'h7a; // 'z'
  localparam logic [7:0] CH_LOWER  = 8'h78; // 'x'

  typedef struct packed {
    logic [1:0] origin;
    logic [1:0] dest;
    logic       up;
    logic [4:0] hi;
    logic [4:0] lo;
    logic [4:0] stop;
    lim_e       lim;
    logic [7:0] start;
    logic [7:0] pre;
    logic       gate;
  } trip_t;

  // Relay bits
  typedef struct packed {
    logic door;
    logic slow;
    logic fast;
    logic down;
    logic up;
  } relay_t;

  function automatic trip_t trip_entry(input logic [3:0] idx);
    trip_t t;
    t = '{2'd0, 2'd1, 1'b1, 5'd2, 5'd4, 5'd6, LIM_NONE, 8'h75, 8'h00, 1'b0};
    case (idx)
      4'd0: t = '{2'd0, 2'd1, 1'b1, 5'd2, 5'd4,  5'd6,  LIM_NONE,  8'h75, 8'h00, 1'b0};
      4'd1: t = '{2'd0, 2'd2, 1'b1, 5'd0, 5'd10, 5'd12, LIM_NONE,  8'h69, 8'h00, 1'b0};
      4'd2: t = '{2'd0, 2'd3, 1'b1, 5'd0, 5'd16, 5'd18, LIM_UPPER, 8'h6f, 8'h00, 1'b0};
      4'd3: t = '{2'd1, 2'd0, 1'b0, 5'd2, 5'd4,  5'd6,  LIM_LOWER, 8'h00, 8'h73, 1'b0};
      4'd4: t = '{2'd1, 2'd2, 1'b1, 5'd0, 5'd4,  5'd6,  LIM_NONE,  8'h71, 8'h00, 1'b0};
      4'd5: t = '{2'd1, 2'd3, 1'b1, 5'd0, 5'd10, 5'd12, LIM_UPPER, 8'h70, 8'h00, 1'b0};
      4'd6: t = '{2'd2, 2'd0, 1'b0, 5'd0, 5'd10, 5'd12, LIM_LOWER, 8'h6b, 8'h00, 1'b0};
      4'd7: t = '{2'd2, 2'd1, 1'b0, 5'd0, 5'd4,  5'd6,  LIM_NONE,  8'h6a, 8'h00, 1'b0};
      4'd8: t = '{2'd2, 2'd3, 1'b1, 5'd0, 5'd4,  5'd6,  LIM_UPPER, 8'h6c, 8'h00, 1'b0};
      4'd9: t = '{2'd3, 2'd0, 1'b0, 5'd0, 5'd16, 5'd18, LIM_LOWER, 8'h76, 8'h00, 1'b0};
      4'd10: t = '{2'd3, 2'd1, 1'b0, 5'd0, 5'd10, 5'd12, LIM_NONE, 8'h6d, 8'h00, 1'b1};
      4'd11: t = '{2'd3, 2'd2, 1'b0, 5'd0, 5'd4,  5'd6,  LIM_NONE, 8'h6e, 8'h00, 1'b0};
      default: ;
    endcase
    return t;
  endfunction

  // floor_state code of the trip from floor f to floor g (f != g)
  function automatic logic [4:0] trip_code(input logic [1:0] f, input logic [1:0] g);
    logic [4:0] c;
    c = 5'd0;
    case ({f, g})
      4'b0001: c = 5'd4;
      4'b0010: c = 5'd5;
      4'b0011: c = 5'd6;
      4'b0100: c = 5'd7;
      4'b0110: c = 5'd8;
      4'b0111: c = 5'd9;
      4'b1000: c = 5'd10;
      4'b1001: c = 5'd11;
      4'b1011: c = 5'd12;
      4'b1100: c = 5'd13;
      4'b1101: c = 5'd14;
      4'b1110: c = 5'd15;
      default: c = {3'b000, f};
    endcase
    return c;
  endfunction

  function automatic logic [7:0] arrive_char(input logic [1:0] f);
    return 8'h43 + {6'd0, f};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/four_floor_elevator_controller_unit.sv
// Elevator controller, 1 ms tick per input transfer. Latency: state is
// updated at the input transfer; results appear the next cycle, 1 to 3
// result transfers per tick. Throughput: one tick per cycle when each tick
// yields one result and output is taken every cycle; a tick with several status
// characters holds the output until the last is taken. Reset (async, active
// low) restores the ground-floor idle state and the register defaults.
`default_nettype none

module four_floor_elevator_controller_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // tick input
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic        uart_valid_i,
  input  wire logic [7:0]  uart_byte_i,
  input  wire logic [3:0]  call_buttons_i,
  input  wire logic        door_open_button_i,
  input  wire logic        door_close_button_i,
  input  wire logic        technician_mode_i,
  input  wire logic        manual_down_i,
  input  wire logic        manual_up_i,
  input  wire logic        position_sensor_i,
  input  wire logic        upper_limit_i,
  input  wire logic        lower_limit_i,
  // results
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic        motor_up_o,
  output      logic        motor_down_o,
  output      logic        fast_speed_o,
  output      logic        slow_speed_o,
  output      logic        door_open_o,
  output      logic [1:0]  floor_shown_o,
  output      logic        fault_o,
  output      logic        report_valid_o,
  output      logic [7:0]  report_char_o,
  output      logic        last_report_o
);

  // configuration registers
  logic [15:0] timeout_q;
  logic [7:0]  settle_q;
  logic [12:0] door_short_q, door_long_q, close_hold_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q    <= 16'd15000;
      settle_q     <= 8'd40;
      door_short_q <= 13'd1000;
      door_long_q  <= 13'd2000;
      close_hold_q <= 13'd5000;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ffec_pkg::CFG_TIMEOUT:    timeout_q    <= cfg_data_i;
        ffec_pkg::CFG_SETTLE:     settle_q     <= cfg_data_i[7:0];
        ffec_pkg::CFG_DOOR_SHORT: door_short_q <= cfg_data_i[12:0];
        ffec_pkg::CFG_DOOR_LONG:  door_long_q  <= cfg_data_i[12:0];
        ffec_pkg::CFG_CLOSE_HOLD: close_hold_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // controller state
  logic [4:0]  floor_q, floor_d;
  logic [1:0]  manual_q, manual_d;
  ffec_pkg::phase_e phase_q, phase_d;
  logic [12:0] timer_q, timer_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [4:0]  edges_q, edges_d;
  logic        prev_q, prev_d;
  logic        primed_q;
  logic        fault_q, fault_d;
  ffec_pkg::relay_t relay_q, relay_d;

  // output register: up to three characters queued
  logic [7:0] rep_q [3];
  logic [1:0] nrep_q, idx_q;
  logic [7:0] rep_d [3];
  logic [1:0] nrep_d;
  logic       ovalid_q;

  logic accept;
  logic out_last;
  assign out_last   = (nrep_q == 2'd0) || (idx_q == nrep_q - 2'd1);
  assign in_ready_o = !ovalid_q || (out_ready_i && out_last);
  assign accept     = in_valid_i && in_ready_o;

  // one tick of control
  always_comb begin
    logic [4:0]  fs;
    logic        trip_ok;
    ffec_pkg::trip_t t;
    logic        sens, prev_eff, done, cnt;
    logic [12:0] tdec;
    logic [16:0] sum;
    logic [1:0]  f, tgt;
    logic        has_tgt;
    logic [12:0] hold;
    logic [4:0]  ne;

    fs = (floor_q > 5'd15) ? 5'd0 : floor_q;
    trip_ok = fs >= 5'd4;
    t = ffec_pkg::trip_entry(trip_ok ? 4'(fs - 5'd4) : 4'd0);
    sens = position_sensor_i;
    prev_eff = primed_q ? prev_q : sens;
    tdec = (timer_q != 13'd0) ? timer_q - 13'd1 : 13'd0;
    done = (tdec == 13'd0);
    f = fs[1:0];
    hold = (f == 2'd1) ? door_short_q : door_long_q;
    tgt = 2'd0;
    has_tgt = 1'b0;
    cnt = 1'b0;
    ne = edges_q;
    sum = 17'd0;

    floor_d = fs;
    manual_d = manual_q;
    phase_d = phase_q;
    timer_d = timer_q;
    elapsed_d = elapsed_q;
    edges_d = edges_q;
    prev_d = prev_eff;
    fault_d = fault_q;
    relay_d = relay_q;
    nrep_d = 2'd0;
    for (int i = 0; i < 3; i++) rep_d[i] = 8'd0;

    case (phase_q)
      ffec_pkg::PH_OPEN_SHUT: begin
        timer_d = tdec;
        if (done) begin
          relay_d.door = 1'b0;
          phase_d = ffec_pkg::PH_SHUT_WAIT;
          timer_d = (fs == 5'd1) ? door_short_q : door_long_q;
        end
      end
      ffec_pkg::PH_OPEN_ONLY: begin
        timer_d = tdec;
        if (done) begin
          relay_d.door = 1'b0;
          phase_d = ffec_pkg::PH_IDLE;
        end
      end
      ffec_pkg::PH_SHUT_WAIT: begin
        timer_d = tdec;
        if (done) phase_d = ffec_pkg::PH_IDLE;
      end
      ffec_pkg::PH_ARRIVE: begin
        timer_d = tdec;
        if (done) begin
          relay_d.door = 1'b0;
          rep_d[0] = ffec_pkg::arrive_char(f);
          nrep_d = 2'd1;
          phase_d = ffec_pkg::PH_IDLE;
        end
      end
      ffec_pkg::PH_RUN: begin
        if (!trip_ok) begin
          phase_d = ffec_pkg::PH_IDLE;
        end else if (sens != prev_eff) begin
          sum = {1'b0, elapsed_q} + {9'd0, settle_q};
          elapsed_d = sum[16] ? 16'hffff : sum[15:0];
          phase_d = ffec_pkg::PH_SETTLE;
          timer_d = {5'd0, settle_q};
        end else if (elapsed_q >= timeout_q) begin
          relay_d = '{door: relay_q.door, default: 1'b0};
          fault_d = 1'b1;
          floor_d = {3'd0, t.origin};
          phase_d = ffec_pkg::PH_IDLE;
        end else begin
          elapsed_d = (elapsed_q == 16'hffff) ? elapsed_q : elapsed_q + 16'd1;
        end
      end
      ffec_pkg::PH_SETTLE: begin
        if (!trip_ok) begin
          phase_d = ffec_pkg::PH_IDLE;
        end else begin
          timer_d = tdec;
          if (done) begin
            cnt = (sens != prev_eff);
            if (cnt && t.gate && upper_limit_i) begin
              rep_d[0] = ffec_pkg::CH_UPPER;
              nrep_d = 2'd1;
              cnt = 1'b0;
            end
            prev_d = sens;
            phase_d = ffec_pkg::PH_RUN;
            if (cnt) begin
              ne = (edges_q < 5'd31) ? edges_q + 5'd1 : edges_q;
              edges_d = ne;
              rep_d[0] = ffec_pkg::CH_TICK;
              nrep_d = 2'd1;
              if (ne == t.hi) begin relay_d.fast = 1'b1; relay_d.slow = 1'b0; end
              if (ne == t.lo) begin relay_d.fast = 1'b0; relay_d.slow = 1'b1; end
              if (ne == t.stop &&
                  !(t.lim == ffec_pkg::LIM_UPPER && !upper_limit_i) &&
                  !(t.lim == ffec_pkg::LIM_LOWER && !lower_limit_i)) begin
                if (t.lim == ffec_pkg::LIM_UPPER) begin
                  rep_d[1] = ffec_pkg::CH_UPPER;
                  nrep_d = 2'd2;
                end else if (t.lim == ffec_pkg::LIM_LOWER) begin
                  rep_d[1] = ffec_pkg::CH_LOWER;
                  nrep_d = 2'd2;
                end
                if (t.pre != 8'd0) begin
                  rep_d[nrep_d] = t.pre;
                  nrep_d = nrep_d + 2'd1;
                end
                relay_d = '{door: 1'b1, default: 1'b0};
                floor_d = {3'd0, t.dest};
                phase_d = ffec_pkg::PH_ARRIVE;
                timer_d = door_short_q;
              end
            end
          end
        end
      end
      default: begin
        phase_d = ffec_pkg::PH_IDLE;
        if (technician_mode_i) begin
          relay_d.door = 1'b0;
          if (manual_q == 2'd1 || manual_q == 2'd2) begin
            fault_d = 1'b0;
            relay_d.fast = 1'b0;
            relay_d.slow = 1'b1;
            relay_d.up   = (manual_q == 2'd1);
            relay_d.down = (manual_q == 2'd2);
          end else begin
            relay_d = '0;
          end
          if (!manual_down_i && manual_up_i)      manual_d = 2'd1;
          else if (manual_down_i && !manual_up_i) manual_d = 2'd2;
          else                                    manual_d = 2'd3;
        end else if (!trip_ok) begin
          if (uart_valid_i) begin
            if (uart_byte_i >= ffec_pkg::CH_FLOOR0 && uart_byte_i <= ffec_pkg::CH_FLOOR3) begin
              has_tgt = 1'b1;
              tgt = 2'(uart_byte_i - ffec_pkg::CH_FLOOR0);
            end
          end else if ($onehot(call_buttons_i)) begin
            has_tgt = 1'b1;
            tgt = call_buttons_i[1] ? 2'd1 : call_buttons_i[2] ? 2'd2 :
                  call_buttons_i[3] ? 2'd3 : 2'd0;
          end else if (door_open_button_i) begin
            relay_d.door = 1'b1;
            phase_d = (f == 2'd3) ? ffec_pkg::PH_OPEN_ONLY : ffec_pkg::PH_OPEN_SHUT;
            timer_d = hold;
          end else if (door_close_button_i) begin
            relay_d.door = 1'b0;
            phase_d = ffec_pkg::PH_SHUT_WAIT;
            timer_d = close_hold_q;
          end
          if (has_tgt) begin
            if (tgt == f) begin
              relay_d.door = 1'b1;
              phase_d = (f <= 2'd1) ? ffec_pkg::PH_OPEN_SHUT : ffec_pkg::PH_OPEN_ONLY;
              timer_d = hold;
            end else begin
              floor_d = ffec_pkg::trip_code(f, tgt);
            end
          end
        end else begin
          fault_d = 1'b0;
          relay_d.up   = t.up;
          relay_d.down = !t.up;
          relay_d.fast = 1'b1;
          relay_d.slow = 1'b0;
          if (t.start != 8'd0) begin
            rep_d[0] = t.start;
            nrep_d = 2'd1;
          end
          edges_d = 5'd0;
          elapsed_d = 16'd0;
          phase_d = ffec_pkg::PH_RUN;
        end
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q   <= 5'd0;
      manual_q  <= 2'd0;
      phase_q   <= ffec_pkg::PH_IDLE;
      timer_q   <= 13'd0;
      elapsed_q <= 16'd0;
      edges_q   <= 5'd0;
      prev_q    <= 1'b0;
      primed_q  <= 1'b0;
      fault_q   <= 1'b0;
      relay_q   <= '0;
    end else if (accept) begin
      floor_q   <= floor_d;
      manual_q  <= manual_d;
      phase_q   <= phase_d;
      timer_q   <= timer_d;
      elapsed_q <= elapsed_d;
      edges_q   <= edges_d;
      prev_q    <= prev_d;
      primed_q  <= 1'b1;
      fault_q   <= fault_d;
      relay_q   <= relay_d;
    end
  end

  // result register and character index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      nrep_q   <= 2'd0;
      idx_q    <= 2'd0;
    end else if (accept) begin
      ovalid_q <= 1'b1;
      nrep_q   <= nrep_d;
      idx_q    <= 2'd0;
    end else if (ovalid_q && out_ready_i) begin
      if (out_last) ovalid_q <= 1'b0;
      else          idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) rep_q[i] <= rep_d[i];
    end
  end

  logic [1:0] shown;
  always_comb begin
    ffec_pkg::trip_t ts;
    ts = ffec_pkg::trip_entry(4'(floor_q - 5'd4));
    if (floor_q < 5'd4)       shown = floor_q[1:0];
    else if (floor_q <= 5'd15) shown = ts.origin;
    else                      shown = 2'd0;
  end

  assign out_valid_o    = ovalid_q;
  assign motor_up_o     = relay_q.up;
  assign motor_down_o   = relay_q.down;
  assign fast_speed_o   = relay_q.fast;
  assign slow_speed_o   = relay_q.slow;
  assign door_open_o    = relay_q.door;
  assign floor_shown_o  = shown;
  assign fault_o        = fault_q;
  assign report_valid_o = (nrep_q != 2'd0);
  assign report_char_o  = (nrep_q != 2'd0) ? rep_q[idx_q] : 8'd0;
  assign last_report_o  = out_last;

endmodule

`default_nettype wire

FILE: rtl/core/ffec_checker.sv
// Port-level checks for the elevator controller, bound to the top level.
// Depends on four_floor_elevator_controller_unit only through its ports.
`default_nettype none

module ffec_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic motor_up_o,
  input wire logic motor_down_o,
  input wire logic fast_speed_o,
  input wire logic slow_speed_o,
  input wire logic report_valid_o,
  input wire logic [7:0] report_char_o,
  input wire logic last_report_o
);

  // direction relays exclude each other
  a_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(motor_up_o && motor_down_o)) else $error("both direction relays on");

  // speed relays exclude each other
  a_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fast_speed_o && slow_speed_o)) else $error("both speed relays on");

  // an empty report carries a zero character and is the only result
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !report_valid_o |-> report_char_o == 8'd0 && last_report_o)
    else $error("empty report malformed");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(report_char_o))
    else $error("stalled result changed");

endmodule

bind four_floor_elevator_controller_unit ffec_checker u_ffec_checker (.*);

`default_nettype wire

FILE: tb/ffec_scoreboard.sv
// Tick predictor and result scoreboard for the four-floor elevator controller.
// Depends on ffec_pkg for phase, limit, register and status character codes.
package ffec_tb_pkg;
  import ffec_pkg::*;

  // One sampled-pin tick as driven on the input channel
  typedef struct packed {
    logic       uv;
    logic [7:0] ub;
    logic [3:0] call;
    logic       dob;
    logic       dcb;
    logic       tech;
    logic       mdn;
    logic       mup;
    logic       sens;
    logic       ulim;
    logic       llim;
  } tick_t;

  // One result as seen on the output channel
  typedef struct packed {
    logic       m_up;
    logic       m_dn;
    logic       fast;
    logic       slow;
    logic       door;
    logic [1:0] shown;
    logic       flt;
    logic       rep_v;
    logic [7:0] rep_c;
    logic       last;
  } status_t;

  typedef struct packed {
    logic [1:0] origin;
    logic [1:0] dest;
    logic       up;
    logic [4:0] hi;
    logic [4:0] lo;
    logic [4:0] stop;
    lim_e       lim;
    logic [7:0] start;
    logic [7:0] pre;
    logic       gate;
  } route_t;

  localparam logic [7:0] ARRIVE_BASE = 8'h43; // 'C' for ground

  class floor_scoreboard;
    // registers
    logic [15:0] tmo;
    logic [7:0]  stl;
    logic [12:0] dshort, dlong, chold;
    // controller state
    logic [4:0]  flr;
    logic [1:0]  mstate;
    phase_e      ph;
    logic [12:0] ptimer;
    logic [15:0] elapsed;
    logic [4:0]  edges;
    logic        prev_s, primed, flt;
    logic        r_up, r_dn, r_fast, r_slow, r_door;
    logic [7:0]  chars[$];
    status_t     status_q[$];
    int          errors;

    function new();
      tmo = 16'd15000; stl = 8'd40; dshort = 13'd1000; dlong = 13'd2000;
      chold = 13'd5000;
      flr = '0; mstate = '0; ph = PH_IDLE; ptimer = '0; elapsed = '0;
      edges = '0; prev_s = 0; primed = 0; flt = 0;
      r_up = 0; r_dn = 0; r_fast = 0; r_slow = 0; r_door = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        CFG_TIMEOUT:    tmo = val;
        CFG_SETTLE:     stl = val[7:0];
        CFG_DOOR_SHORT: dshort = val[12:0];
        CFG_DOOR_LONG:  dlong = val[12:0];
        CFG_CLOSE_HOLD: chold = val[12:0];
        default: ;
      endcase
    endfunction

    function route_t route(logic [3:0] i);
      route_t r;
      r = '{2'd0, 2'd1, 1'b1, 5'd2, 5'd4, 5'd6, LIM_NONE, "u", 8'h00, 1'b0};
      case (i)
        4'd1:  r = '{2'd0, 2'd2, 1'b1, 5'd0, 5'd10, 5'd12, LIM_NONE,  "i", 8'h00, 1'b0};
        4'd2:  r = '{2'd0, 2'd3, 1'b1, 5'd0, 5'd16, 5'd18, LIM_UPPER, "o", 8'h00, 1'b0};
        4'd3:  r = '{2'd1, 2'd0, 1'b0, 5'd2, 5'd4,  5'd6,  LIM_LOWER, 8'h00, "s", 1'b0};
        4'd4:  r = '{2'd1, 2'd2, 1'b1, 5'd0, 5'd4,  5'd6,  LIM_NONE,  "q", 8'h00, 1'b0};
        4'd5:  r = '{2'd1, 2'd3, 1'b1, 5'd0, 5'd10, 5'd12, LIM_UPPER, "p", 8'h00, 1'b0};
        4'd6:  r = '{2'd2, 2'd0, 1'b0, 5'd0, 5'd10, 5'd12, LIM_LOWER, "k", 8'h00, 1'b0};
        4'd7:  r = '{2'd2, 2'd1, 1'b0, 5'd0, 5'd4,  5'd6,  LIM_NONE,  "j", 8'h00, 1'b0};
        4'd8:  r = '{2'd2, 2'd3, 1'b1, 5'd0, 5'd4,  5'd6,  LIM_UPPER, "l", 8'h00, 1'b0};
        4'd9:  r = '{2'd3, 2'd0, 1'b0, 5'd0, 5'd16, 5'd18, LIM_LOWER, "v", 8'h00, 1'b0};
        4'd10: r = '{2'd3, 2'd1, 1'b0, 5'd0, 5'd10, 5'd12, LIM_NONE,  "m", 8'h00, 1'b1};
        4'd11: r = '{2'd3, 2'd2, 1'b0, 5'd0, 5'd4,  5'd6,  LIM_NONE,  "n", 8'h00, 1'b0};
        default: ;
      endcase
      return r;
    endfunction

    function void say(logic [7:0] c);
      if (chars.size() < 3) chars.push_back(c);
    endfunction

    function void arm(phase_e p, logic [12:0] n);
      ph = p;
      ptimer = n;
    endfunction

    function bit timer_done();
      if (ptimer != 0) ptimer--;
      return ptimer == 0;
    endfunction

    function void set_dir(logic up);
      r_up = up; r_dn = !up;
    endfunction

    function void set_speed(logic fast_sel);
      r_fast = fast_sel; r_slow = !fast_sel;
    endfunction

    function void motors_off();
      r_up = 0; r_dn = 0; r_fast = 0; r_slow = 0;
    endfunction

    function logic [15:0] sat_add(logic [15:0] a, logic [15:0] b);
      logic [16:0] s;
      s = a + b;
      return s[16] ? 16'hffff : s[15:0];
    endfunction

    // Floor selection and door buttons while resting
    function void idle_step(tick_t t);
      logic [1:0]  f;
      logic [12:0] hold;
      int          goal;
      f = flr[1:0];
      hold = (f == 2'd1) ? dshort : dlong;
      goal = -1;
      if (t.uv) begin
        if (t.ub >= CH_FLOOR0 && t.ub <= CH_FLOOR3) goal = t.ub - CH_FLOOR0;
      end else if ($countones(t.call) == 1) begin
        goal = (t.call[0]) ? 0 : (t.call[1]) ? 1 : (t.call[2]) ? 2 : 3;
      end else if (t.dob) begin
        r_door = 1;
        arm(f == 2'd3 ? PH_OPEN_ONLY : PH_OPEN_SHUT, hold);
      end else if (t.dcb) begin
        r_door = 0;
        arm(PH_SHUT_WAIT, chold);
      end
      if (goal < 0) return;
      if (goal == f) begin
        r_door = 1;
        arm(f <= 2'd1 ? PH_OPEN_SHUT : PH_OPEN_ONLY, hold);
      end else begin
        flr = 5'd4 + f * 3 + ((goal > f) ? goal - 1 : goal);
      end
    endfunction

    function void tech_step(tick_t t);
      r_door = 0;
      if (mstate == 2'd1) begin
        flt = 0; set_speed(0); set_dir(1);
      end else if (mstate == 2'd2) begin
        flt = 0; set_speed(0); set_dir(0);
      end else begin
        motors_off();
      end
      if (!t.mdn && t.mup) mstate = 2'd1;
      else if (t.mdn && !t.mup) mstate = 2'd2;
      else mstate = 2'd3;
    endfunction

    // End of a settling wait: count the edge and check the trip table
    function void settle_step(tick_t t, route_t r);
      bit hit;
      hit = (t.sens != prev_s);
      if (hit && r.gate && t.ulim) begin
        say(CH_UPPER);
        hit = 0;
      end
      prev_s = t.sens;
      ph = PH_RUN;
      if (!hit) return;
      if (edges != 5'd31) edges++;
      say(CH_TICK);
      if (edges == r.hi) set_speed(1);
      if (edges == r.lo) set_speed(0);
      if (edges != r.stop) return;
      if (r.lim == LIM_UPPER) begin
        if (!t.ulim) return;
        say(CH_UPPER);
      end else if (r.lim == LIM_LOWER) begin
        if (!t.llim) return;
        say(CH_LOWER);
      end
      motors_off();
      if (r.pre != 0) say(r.pre);
      flr = {3'b000, r.dest};
      r_door = 1;
      arm(PH_ARRIVE, dshort);
    endfunction

    function void run_step(tick_t t, route_t r);
      if (t.sens != prev_s) begin
        elapsed = sat_add(elapsed, {8'd0, stl});
        arm(PH_SETTLE, {5'd0, stl});
      end else if (elapsed >= tmo) begin
        motors_off();
        flt = 1;
        flr = {3'b000, r.origin};
        ph = PH_IDLE;
      end else begin
        elapsed = sat_add(elapsed, 16'd1);
      end
    endfunction

    // Advance one tick and queue the results it causes
    function void note_tick(tick_t t);
      bit      on_trip;
      route_t  r;
      status_t s;
      int      n;
      chars.delete();
      if (!primed) begin
        prev_s = t.sens;
        primed = 1;
      end
      if (flr > 5'd15) flr = '0;
      on_trip = flr >= 5'd4;
      r = route(on_trip ? flr - 5'd4 : 4'd0);
      case (ph)
        PH_OPEN_SHUT: if (timer_done()) begin
          r_door = 0;
          arm(PH_SHUT_WAIT, flr == 5'd1 ? dshort : dlong);
        end
        PH_OPEN_ONLY: if (timer_done()) begin
          r_door = 0;
          ph = PH_IDLE;
        end
        PH_SHUT_WAIT: if (timer_done()) ph = PH_IDLE;
        PH_ARRIVE: if (timer_done()) begin
          r_door = 0;
          say(ARRIVE_BASE + flr[1:0]);
          ph = PH_IDLE;
        end
        PH_RUN: begin
          if (on_trip) run_step(t, r);
          else ph = PH_IDLE;
        end
        PH_SETTLE: begin
          if (!on_trip) ph = PH_IDLE;
          else if (timer_done()) settle_step(t, r);
        end
        default: begin
          ph = PH_IDLE;
          if (t.tech) begin
            tech_step(t);
          end else if (!on_trip) begin
            idle_step(t);
          end else begin
            flt = 0;
            set_dir(r.up);
            set_speed(1);
            if (r.start != 0) say(r.start);
            edges = '0;
            elapsed = '0;
            ph = PH_RUN;
          end
        end
      endcase
      s.m_up = r_up; s.m_dn = r_dn; s.fast = r_fast; s.slow = r_slow; s.door = r_door;
      s.shown = (flr < 5'd4) ? flr[1:0] : route(flr - 5'd4).origin;
      s.flt = flt;
      n = (chars.size() > 0) ? chars.size() : 1;
      for (int k = 0; k < n; k++) begin
        s.rep_v = k < chars.size();
        s.rep_c = (k < chars.size()) ? chars[k] : 8'h00;
        s.last = (k == n - 1);
        status_q.push_back(s);
      end
    endfunction

    function void check_result(status_t act);
      status_t want;
      if (status_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, act);
        errors++;
        return;
      end
      want = status_q.pop_front();
      if (want !== act) begin
        $display("%0t: result mismatch expected %p actual %p", $time, want, act);
        errors++;
      end
    endfunction
  endclass
endpackage

FILE: tb/tb_top.sv
// Top-level testbench of the four-floor elevator controller: drives ticks and
// register writes, checks every result. Depends on ffec_pkg and ffec_tb_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ffec_pkg::*;
  import ffec_tb_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int RANDOM_TICKS = 260;

  logic        clk_i = 0, rst_ni = 0;
  logic        cfg_valid_i = 0, cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 0, in_ready_o;
  tick_t       pins = '0;
  logic        out_valid_o, out_ready_i = 0;
  status_t     seen;

  floor_scoreboard sb = new();
  int  cycles = 0;
  int  rnd_ticks = 0;
  bit  calm = 0;
  logic sensor = 0;

  four_floor_elevator_controller_unit dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o,
    .uart_valid_i(pins.uv), .uart_byte_i(pins.ub), .call_buttons_i(pins.call),
    .door_open_button_i(pins.dob), .door_close_button_i(pins.dcb),
    .technician_mode_i(pins.tech), .manual_down_i(pins.mdn), .manual_up_i(pins.mup),
    .position_sensor_i(pins.sens), .upper_limit_i(pins.ulim), .lower_limit_i(pins.llim),
    .out_valid_o, .out_ready_i,
    .motor_up_o(seen.m_up), .motor_down_o(seen.m_dn), .fast_speed_o(seen.fast),
    .slow_speed_o(seen.slow), .door_open_o(seen.door), .floor_shown_o(seen.shown),
    .fault_o(seen.flt), .report_valid_o(seen.rep_v), .report_char_o(seen.rep_c),
    .last_report_o(seen.last)
  );

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver side: random stalls, changed at the falling edge
  int stall = 0;
  always @(negedge clk_i) begin
    if (stall > 0) begin
      out_ready_i <= 0;
      stall <= stall - 1;
    end else begin
      out_ready_i <= 1;
      stall <= pick_gap();
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(seen);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // One tick transfer; valid stays up until the caller drops it
  task automatic send_tick(tick_t t);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 0;
    end
    @(negedge clk_i);
    pins = t;
    in_valid_i = 1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_tick(t);
  endtask

  task automatic drop_tick();
    @(negedge clk_i);
    in_valid_i = 0;
  endtask

  function automatic tick_t quiet_tick();
    tick_t t;
    t = '0;
    t.sens = sensor;
    return t;
  endfunction

  function automatic tick_t noise_tick();
    tick_t t;
    t = tick_t'($urandom);
    sensor = t.sens;
    return t;
  endfunction

  // Quiet ticks until the car rests with no timed phase running
  task automatic settle_down();
    int n;
    n = 0;
    while ((sb.ph != PH_IDLE || sb.flr >= 5'd4) && n < 30000) begin
      send_tick(quiet_tick());
      n++;
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    drop_tick();
    while (sb.status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_index_i = idx;
    cfg_data_i = val;
    cfg_valid_i = 1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 0;
  endtask

  task automatic setup(logic [15:0] tmo, logic [7:0] stl, logic [12:0] ds,
                       logic [12:0] dl, logic [12:0] ch);
    settle_down();
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_SETTLE, {8'd0, stl});
    write_reg(CFG_DOOR_SHORT, {3'd0, ds});
    write_reg(CFG_DOOR_LONG, {3'd0, dl});
    write_reg(CFG_CLOSE_HOLD, {3'd0, ch});
  endtask

  // Select a floor, then run sensor edges until the car stops or faults
  task automatic run_trip();
    tick_t t;
    int    goal, hold, cap, n;
    logic  keep;
    settle_down();
    goal = $urandom_range(0, 3);
    if (goal == sb.flr[1:0]) goal = (goal + 1) % 4;
    t = noise_tick();
    t.tech = 0;
    if ($urandom_range(0, 1)) begin
      t.uv = 1;
      t.ub = CH_FLOOR0 + goal;
    end else begin
      t.uv = 0;
      t.call = 4'b0001 << goal;
    end
    send_tick(t);
    cap = (sb.stl + 3) * 45 + 60;
    hold = 0;
    n = 0;
    while (sb.flr >= 5'd4 && n < cap) begin
      keep = sensor;
      t = noise_tick();
      t.sens = keep;
      if (hold <= 0) begin
        t.sens = !keep;
        hold = sb.stl + 1 + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : 0);
        // occasional glitch that does not hold through settling
        if ($urandom_range(0, 11) == 0) hold = 0;
      end
      hold--;
      t.ulim = (goal == 3) ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 9) < 2);
      t.llim = (goal == 0) ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 9) < 2);
      sensor = t.sens;
      send_tick(t);
      n++;
      rnd_ticks++;
    end
  endtask

  task automatic directed();
    tick_t t;
    logic [7:0] bytes[6];
    bytes = '{8'h00, 8'hff, 8'h30, 8'h35, CH_FLOOR0, CH_FLOOR3};
    foreach (bytes[i]) begin
      settle_down();
      t = quiet_tick();
      t.uv = 1; t.ub = bytes[i];
      t.call = 4'b0100;
      send_tick(t);
    end
    settle_down();
    t = quiet_tick(); t.call = 4'b1111; send_tick(t);
    t = quiet_tick(); t.call = 4'b0011; t.dob = 1; send_tick(t);
    settle_down();
    t = quiet_tick(); t.dcb = 1; send_tick(t);
    settle_down();
    t = quiet_tick(); t.dob = 1; t.dcb = 1; send_tick(t);
    settle_down();
    // technician mode: up, down, both, none, then leave
    t = quiet_tick(); t.tech = 1; t.mup = 1; send_tick(t); send_tick(t);
    t.mup = 0; t.mdn = 1; send_tick(t); send_tick(t);
    t.mup = 1; send_tick(t); send_tick(t);
    t.mup = 0; t.mdn = 0; send_tick(t);
    t = quiet_tick(); send_tick(t);
    t = '1; sensor = 1; send_tick(t);
  endtask

  initial begin
    int choice;
    tick_t t;
    repeat (2) @(negedge clk_i);
    rst_ni = 1;

    // reset defaults, then short timers for the directed part
    send_tick(quiet_tick());
    setup(16'd300, 8'd1, 13'd3, 13'd5, 13'd4);
    directed();
    run_trip();

    // longer timeout and settling, then smallest values
    setup(16'd900, 8'd6, 13'd12, 13'd16, 13'd10);
    run_trip();
    setup(16'd1, 8'd0, 13'd0, 13'd0, 13'd0);
    run_trip();
    run_trip();

    while (rnd_ticks < RANDOM_TICKS) begin
      calm = ($urandom_range(0, 3) == 0);
      setup($urandom_range(20, 400), $urandom_range(0, 3), $urandom_range(0, 6),
            $urandom_range(0, 8), $urandom_range(0, 6));
      repeat (6) begin
        choice = $urandom_range(0, 99);
        if (choice < 60) begin
          run_trip();
        end else if (choice < 75) begin
          settle_down();
          t = quiet_tick();
          t.dob = $urandom_range(0, 1); t.dcb = $urandom_range(0, 1);
          t.uv = $urandom_range(0, 3) == 0; t.ub = $urandom;
          send_tick(t);
          rnd_ticks++;
        end else if (choice < 85) begin
          repeat ($urandom_range(2, 6)) begin
            t = noise_tick(); t.tech = 1;
            send_tick(t);
            rnd_ticks++;
          end
        end else begin
          repeat ($urandom_range(1, 5)) begin
            send_tick(noise_tick());
            rnd_ticks++;
          end
        end
      end
    end
    calm = 0;
    drop_tick();

    while (sb.status_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.status_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
